// File: hdl/wbps_pkg.sv
// Shared constants, register indexes and result type for the byte signature scan.
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF       = 32;
  localparam int SIG_REG_BYTES         = 16;
  localparam int ADDR_BITS             = 64;
  localparam int LEN_BITS              = 5;
  localparam int MASK_BITS             = 16;
  localparam int CFG_IDX_BITS          = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WILDCARD     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE         = 3'd4;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] addr;
  } res_t;

  // usable signature length: the smaller of the window limit and the register size
  function automatic int sig_limit(int max_bytes);
    sig_limit = (max_bytes < SIG_REG_BYTES) ? max_bytes : SIG_REG_BYTES;
  endfunction

endpackage

// File: hdl/wbps_match.sv
// Parallel window compare against the masked signature, plus match address.
module wbps_match #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic [7:0]                                               cur_byte,
  input  logic [(wbps_pkg::sig_limit(MAX_PATTERN_BYTES)-1)*8-1:0]  window,
  input  logic [OFFSET_BITS-1:0]                                   byte_offset,
  input  logic [2*wbps_pkg::ADDR_BITS-1:0]                         pattern,
  input  logic [wbps_pkg::MASK_BITS-1:0]                           wildcard_mask,
  input  logic [wbps_pkg::LEN_BITS-1:0]                            pattern_length,
  input  logic [wbps_pkg::ADDR_BITS-1:0]                           base_address,
  output logic                                                     hit,
  output logic [wbps_pkg::ADDR_BITS-1:0]                           hit_address
);
  import wbps_pkg::*;

  localparam int LIM = sig_limit(MAX_PATTERN_BYTES);

  logic [LEN_BITS-1:0] eff_len;
  logic [LEN_BITS-1:0] eff_m1;
  logic [LIM-1:0]      pos_ok;
  logic                offset_ok;

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (pattern_length > LEN_BITS'(LIM)) begin
      eff_len = LEN_BITS'(LIM);
    end else begin
      eff_len = pattern_length;
    end
    eff_m1 = eff_len - LEN_BITS'(1);
  end

  // position 0 is the incoming byte, position i the byte i steps back;
  // it lines up with signature byte len-1-i
  for (genvar i = 0; i < LIM; i++) begin : g_pos
    logic [7:0]          img_byte;
    logic [LEN_BITS-1:0] sig_idx;
    logic [7:0]          sig_byte;
    logic                active;
    if (i == 0) begin : g_cur
      assign img_byte = cur_byte;
    end else begin : g_win
      assign img_byte = window[(i-1)*8 +: 8];
    end
    assign active   = LEN_BITS'(i) < eff_len;
    assign sig_idx  = eff_m1 - LEN_BITS'(i);
    assign sig_byte = pattern[{sig_idx[3:0], 3'b000} +: 8];
    assign pos_ok[i] = !active || wildcard_mask[sig_idx[3:0]] || (img_byte == sig_byte);
  end

  assign offset_ok = (byte_offset != '1) && (byte_offset >= OFFSET_BITS'(eff_m1));
  assign hit       = offset_ok && (&pos_ok);
  assign hit_address = base_address + ADDR_BITS'(byte_offset) - ADDR_BITS'(eff_m1);

endmodule

// File: hdl/wbps_out_buf.sv
// Two-entry result buffer: head register plus skid slot.
module wbps_out_buf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  wbps_pkg::res_t               push_res,
  output logic                         full,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic                         m_tuser,   // found
  output logic [wbps_pkg::ADDR_BITS-1:0] m_tdata  // match_address
);
  import wbps_pkg::*;

  logic head_valid;
  logic skid_valid;
  res_t head;
  res_t skid;
  logic pop;

  assign pop      = head_valid && m_tready;
  assign full     = skid_valid;
  assign m_tvalid = head_valid;
  assign m_tuser  = head.found;
  assign m_tdata  = head.addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          head       <= skid;
          skid_valid <= 1'b0;
        end else if (push) begin
          head <= push_res;
        end else begin
          head_valid <= 1'b0;
        end
      end else if (push) begin
        if (!head_valid) begin
          head       <= push_res;
          head_valid <= 1'b1;
        end else begin
          skid       <= push_res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/wildcard_byte_pattern_scan.sv
// Top level of the wildcard byte signature scan.
// Image bytes enter on the s_ side, one byte per cycle; every byte is compared
// in the cycle it is accepted against the incoming byte and the previous
// 15 bytes held in a shift window, and a result (found plus address) is
// registered into a two-entry output buffer. The sustained rate is one byte
// per cycle, set by the parallel window compare; s_tready drops only while
// both output entries are occupied. At most one result per image: found=1 at
// the first match, or found=0 with address 0 when the image ends unmatched.
// The window, offset and result flag clear after each last byte.
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wbps_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wbps_pkg::ADDR_BITS-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic                              s_tlast,   // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic                              m_tuser,   // found
  output logic [wbps_pkg::ADDR_BITS-1:0]    m_tdata    // match_address
);
  import wbps_pkg::*;

  localparam int LIM = sig_limit(MAX_PATTERN_BYTES);
  localparam int WIN = LIM - 1;

  logic [ADDR_BITS-1:0] pattern_low;
  logic [ADDR_BITS-1:0] pattern_high;
  logic [MASK_BITS-1:0] wildcard_mask;
  logic [LEN_BITS-1:0]  pattern_length;
  logic [ADDR_BITS-1:0] base_address;

  logic [7:0]             byte_window [WIN];
  logic [WIN*8-1:0]       window_flat;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   result_given;

  logic                 accept;
  logic                 hit;
  logic [ADDR_BITS-1:0] hit_address;
  logic                 full;
  logic                 push;
  res_t                 push_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= LEN_BITS'(1);
      base_address   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_WILDCARD:     wildcard_mask  <= cfg_data[MASK_BITS-1:0];
        REG_LENGTH:       pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_BASE:         base_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar w = 0; w < WIN; w++) begin : g_flat
    assign window_flat[w*8 +: 8] = byte_window[w];
  end

  wbps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_match (
    .cur_byte      (s_tdata),
    .window        (window_flat),
    .byte_offset   (byte_offset),
    .pattern       ({pattern_high, pattern_low}),
    .wildcard_mask (wildcard_mask),
    .pattern_length(pattern_length),
    .base_address  (base_address),
    .hit           (hit),
    .hit_address   (hit_address)
  );

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // a match wins over the end-of-image miss word
  always_comb begin
    push           = 1'b0;
    push_res.found = 1'b0;
    push_res.addr  = '0;
    if (accept && !result_given) begin
      if (hit) begin
        push           = 1'b1;
        push_res.found = 1'b1;
        push_res.addr  = hit_address;
      end else if (s_tlast) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      result_given <= 1'b0;
      for (int k = 0; k < WIN; k++) begin
        byte_window[k] <= '0;
      end
    end else if (accept) begin
      if (s_tlast) begin
        byte_offset  <= '0;
        result_given <= 1'b0;
        for (int k = 0; k < WIN; k++) begin
          byte_window[k] <= '0;
        end
      end else begin
        if (push) begin
          result_given <= 1'b1;
        end
        if (byte_offset != '1) begin
          byte_offset <= byte_offset + OFFSET_BITS'(1);
        end
        byte_window[0] <= s_tdata;
        for (int k = 1; k < WIN; k++) begin
          byte_window[k] <= byte_window[k-1];
        end
      end
    end
  end

  wbps_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_res(push_res),
    .full    (full),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

endmodule
